FILE: hdl/chpt_pkg.sv
// shared constants and types of the chained hash page table
package chpt_pkg;

  localparam int unsigned NUM_BUCKETS  = 256;
  localparam int unsigned POOL_ENTRIES = 1024;
  localparam int unsigned BKT_W        = $clog2(NUM_BUCKETS);
  localparam int unsigned IDX_W        = $clog2(POOL_ENTRIES);
  localparam int unsigned PTR_W        = IDX_W + 1;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned PAGE_W       = 32;
  localparam int unsigned LINK_W       = 16;

  localparam logic [PTR_W-1:0] NO_SLOT  = PTR_W'(POOL_ENTRIES);
  localparam logic [PTR_W-1:0] POOL_CNT = PTR_W'(POOL_ENTRIES);

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [PAGE_W-1:0] page_number;
    logic [LINK_W-1:0] link_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LINK_W-1:0] found_link;
    logic [IDX_W-1:0]  entry_index;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [LINK_W-1:0] link;
    logic [PTR_W-1:0]  next;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HEAD,
    S_WALK
  } state_e;

endpackage

FILE: hdl/chpt_ram.sv
// generic single-port-write ram with registered read
module chpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/chpt_mod.sv
// iterative remainder unit: page number modulo bucket count, four bits a cycle
module chpt_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [chpt_pkg::PAGE_W-1:0]      dividend_i,
  input  logic [chpt_pkg::CFG_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [chpt_pkg::BKT_W-1:0]       rem_o
);

  localparam int unsigned STEPS = chpt_pkg::PAGE_W / 4;

  logic                         busy_q, done_q;
  logic [$clog2(STEPS)-1:0]     cnt_q;
  logic [chpt_pkg::CFG_W-1:0]   rem_q, rem_d, div_q;
  logic [chpt_pkg::PAGE_W-1:0]  page_q, page_d;

  // four restoring steps
  always_comb begin
    rem_d  = rem_q;
    page_d = page_q;
    for (int i = 0; i < 4; i++) begin
      rem_d  = {rem_d[chpt_pkg::CFG_W-2:0], page_d[chpt_pkg::PAGE_W-1]};
      page_d = {page_d[chpt_pkg::PAGE_W-2:0], 1'b0};
      if (rem_d >= div_q) begin
        rem_d = rem_d - div_q;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(STEPS))'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      page_q <= dividend_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      page_q <= page_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[chpt_pkg::BKT_W-1:0];

endmodule

FILE: hdl/chained_hash_page_table.sv
// top level of the chained hash page table
//
// A command beat is taken when start_i is high and busy_o is low; req_i holds
// op, page_number and link_value. Exactly one result beat follows, shown on
// rsp_o for one cycle with done_o high; the receiver cannot hold it off.
// The bucket register is written on the cfg channel (cfg_valid_i and
// cfg_ready_o); the user must write it only while the block is idle, and
// the block does not enforce this. Values 0 and above 256 act as 1 and 256.
// The remainder unit makes four quotient bits a cycle; when it is done, S_DIV
// issues the bucket and free-stack reads and S_HEAD uses them, then S_WALK
// visits the chain in the entry memory link by link. An insert ends in
// S_HEAD, a lookup or delete in S_HEAD or S_WALK, an insert into a full pool
// or an unused op code in S_DIV.
// One command is in flight at a time; busy_o is high until the result.
// Reset clears the bucket heads through one valid flop per bucket and hands
// out never-used pool slots from a fresh mark, so no clearing pass is run
// and the block takes a command in the first cycle after reset.
// State lives in three memories: bucket heads, entries, free stack.
module chained_hash_page_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  chpt_pkg::req_t              req_i,
  output logic                        done_o,
  output chpt_pkg::rsp_t              rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [chpt_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = chpt_pkg::PTR_W;
  localparam int unsigned IW = chpt_pkg::IDX_W;
  localparam int unsigned BW = chpt_pkg::BKT_W;
  localparam int unsigned EW = $bits(chpt_pkg::entry_t);

  chpt_pkg::state_e state_q, state_d;
  chpt_pkg::req_t   req_q;
  chpt_pkg::rsp_t   rsp_q, rsp_d;
  chpt_pkg::entry_t e_rd, e_wd, prev_q, prev_d;
  logic                        done_q, done_d;
  logic [chpt_pkg::CFG_W-1:0]  cfg_q, n_eff;
  logic [PW-1:0]               fc_q, fc_d, fresh_q, fresh_d, cur_q, cur_d;
  logic [PW-1:0]               prev_idx_q, prev_idx_d, head, slot;
  logic [BW-1:0]               bkt_q, bkt_d;
  logic [chpt_pkg::NUM_BUCKETS-1:0] hval_q, hval_d;
  logic                        mod_start, mod_done;
  logic [BW-1:0]               mod_rem;

  logic          h_we;
  logic [BW-1:0] h_ra;
  logic [PW-1:0] h_wd, h_rd;
  logic          e_we;
  logic [IW-1:0] e_wa, e_ra;
  logic          s_we;
  logic [IW-1:0] s_wa, s_ra, s_wd, s_rd;

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= chpt_pkg::CFG_W'(chpt_pkg::NUM_BUCKETS);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // clamp the divisor into range
  always_comb begin
    n_eff = cfg_q;
    if (cfg_q == '0) begin
      n_eff = chpt_pkg::CFG_W'(1);
    end else if (cfg_q > chpt_pkg::CFG_W'(chpt_pkg::NUM_BUCKETS)) begin
      n_eff = chpt_pkg::CFG_W'(chpt_pkg::NUM_BUCKETS);
    end
  end

  assign mod_start = (state_q == chpt_pkg::S_IDLE) && start_i;

  chpt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (req_i.page_number),
    .divisor_i  (n_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  chpt_ram #(.WIDTH(PW), .DEPTH(chpt_pkg::NUM_BUCKETS)) u_heads (
    .clk_i (clk_i), .we_i (h_we), .waddr_i (bkt_q), .wdata_i (h_wd),
    .raddr_i (h_ra), .rdata_o (h_rd)
  );

  chpt_ram #(.WIDTH(EW), .DEPTH(chpt_pkg::POOL_ENTRIES)) u_entries (
    .clk_i (clk_i), .we_i (e_we), .waddr_i (e_wa), .wdata_i (e_wd),
    .raddr_i (e_ra), .rdata_o (e_rd)
  );

  chpt_ram #(.WIDTH(IW), .DEPTH(chpt_pkg::POOL_ENTRIES)) u_free (
    .clk_i (clk_i), .we_i (s_we), .waddr_i (s_wa), .wdata_i (s_wd),
    .raddr_i (s_ra), .rdata_o (s_rd)
  );

  assign h_ra = mod_rem;
  assign s_ra = IW'(fc_q - 1'b1);
  assign head = hval_q[bkt_q] ? h_rd : chpt_pkg::NO_SLOT;
  // slots below the fresh mark were never pushed back and hold their reset order
  assign slot = (fc_q == fresh_q) ? (chpt_pkg::POOL_CNT - fc_q) : PW'(s_rd);

  // next state, memory accesses and result
  always_comb begin
    state_d    = state_q;
    rsp_d      = '0;
    done_d     = 1'b0;
    fc_d       = fc_q;
    fresh_d    = fresh_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    prev_idx_d = prev_idx_q;
    bkt_d      = bkt_q;
    hval_d     = hval_q;
    h_we       = 1'b0;
    h_wd       = head;
    e_we       = 1'b0;
    e_wa       = cur_q[IW-1:0];
    e_wd       = '0;
    e_ra       = cur_q[IW-1:0];
    s_we       = 1'b0;
    s_wa       = fc_q[IW-1:0];
    s_wd       = cur_q[IW-1:0];
    unique case (state_q)
      chpt_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = chpt_pkg::S_DIV;
        end
      end
      chpt_pkg::S_DIV: begin
        if (mod_done) begin
          bkt_d = mod_rem;
          if (req_q.op == chpt_pkg::OP_INSERT && fc_q == '0) begin
            rsp_d.status = chpt_pkg::ST_FULL;
            done_d  = 1'b1;
            state_d = chpt_pkg::S_IDLE;
          end else if (req_q.op == chpt_pkg::OP_LOOKUP || req_q.op == chpt_pkg::OP_INSERT ||
                       req_q.op == chpt_pkg::OP_DELETE) begin
            state_d = chpt_pkg::S_HEAD;
          end else begin
            rsp_d.status = chpt_pkg::ST_MISSING;
            done_d  = 1'b1;
            state_d = chpt_pkg::S_IDLE;
          end
        end
      end
      chpt_pkg::S_HEAD: begin
        if (req_q.op == chpt_pkg::OP_INSERT) begin
          // pop a slot and push it on the chain head
          e_we   = 1'b1;
          e_wa   = slot[IW-1:0];
          e_wd   = '{page: req_q.page_number, link: req_q.link_value, next: head};
          h_we   = 1'b1;
          h_wd   = slot;
          hval_d[bkt_q] = 1'b1;
          fc_d   = fc_q - 1'b1;
          if (fc_q == fresh_q) begin
            fresh_d = fresh_q - 1'b1;
          end
          rsp_d.status      = chpt_pkg::ST_OK;
          rsp_d.entry_index = slot[IW-1:0];
          done_d  = 1'b1;
          state_d = chpt_pkg::S_IDLE;
        end else if (head >= chpt_pkg::NO_SLOT) begin
          rsp_d.status = chpt_pkg::ST_MISSING;
          done_d  = 1'b1;
          state_d = chpt_pkg::S_IDLE;
        end else begin
          prev_idx_d = chpt_pkg::NO_SLOT;
          cur_d   = head;
          e_ra    = head[IW-1:0];
          state_d = chpt_pkg::S_WALK;
        end
      end
      chpt_pkg::S_WALK: begin
        if (e_rd.page == req_q.page_number) begin
          rsp_d.status      = chpt_pkg::ST_OK;
          rsp_d.entry_index = cur_q[IW-1:0];
          if (req_q.op == chpt_pkg::OP_LOOKUP) begin
            rsp_d.found_link = e_rd.link;
          end else begin
            // unlink and return the slot to the pool
            if (prev_idx_q >= chpt_pkg::NO_SLOT) begin
              h_we = 1'b1;
              h_wd = e_rd.next;
            end else begin
              e_we = 1'b1;
              e_wa = prev_idx_q[IW-1:0];
              e_wd = '{page: prev_q.page, link: prev_q.link, next: e_rd.next};
            end
            if (fc_q < chpt_pkg::POOL_CNT) begin
              s_we = 1'b1;
              fc_d = fc_q + 1'b1;
            end
          end
          done_d  = 1'b1;
          state_d = chpt_pkg::S_IDLE;
        end else if (e_rd.next >= chpt_pkg::NO_SLOT) begin
          rsp_d.status = chpt_pkg::ST_MISSING;
          done_d  = 1'b1;
          state_d = chpt_pkg::S_IDLE;
        end else begin
          prev_idx_d = cur_q;
          prev_d     = e_rd;
          cur_d      = e_rd.next;
          e_ra       = e_rd.next[IW-1:0];
        end
      end
      default: begin
        state_d = chpt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chpt_pkg::S_IDLE;
      done_q  <= 1'b0;
      fc_q    <= chpt_pkg::POOL_CNT;
      fresh_q <= chpt_pkg::POOL_CNT;
      hval_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      fc_q    <= fc_d;
      fresh_q <= fresh_d;
      hval_q  <= hval_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mod_start) begin
      req_q <= req_i;
    end
    rsp_q      <= rsp_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_idx_q <= prev_idx_d;
    bkt_q      <= bkt_d;
  end

  assign busy_o = (state_q != chpt_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  a_fc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= chpt_pkg::POOL_CNT) else $error("free count above pool size");
  a_fresh : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= fc_q) else $error("fresh mark above free count");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == chpt_pkg::ST_FULL) |-> fc_q == '0)
    else $error("pool full reported with free slots");

endmodule
